[src/go_to_goal_heading_controller_assert.svh]
// Assertion macros for the go-to-goal heading controller
`ifndef GO_TO_GOAL_HEADING_CONTROLLER_ASSERT_SVH
`define GO_TO_GOAL_HEADING_CONTROLLER_ASSERT_SVH
`ifndef ASSERT_OFF
`define GTG_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GTG_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GTG_ASSERT_IMPL(label, clk, rst, prop, msg)
`define GTG_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

[src/gtg_pkg.sv]
// Shared types and constants of the go-to-goal heading controller
package gtg_pkg;
   localparam int CordicIterationsDefault = 18;
   localparam int AtanEntries = 24;
   localparam int ZW = 28;   // Q24 angle plus sign/headroom
   localparam int VW = 37;   // CORDIC x/y width (25 bit diff, 8 guard, growth)
   localparam logic signed [ZW-1:0] HalfPiQ24 = 28'sd26353589;
   localparam logic signed [20:0] PiQ16 = 21'sd205887;
   localparam logic signed [20:0] TwoPiQ16 = 21'sd411775;
   localparam logic [23:0] CordicKQ24 = 24'd10188014;
   localparam logic signed [23:0] GoalReset = 24'sd363361;

   localparam logic [1:0] RegLinearGain = 2'd0;
   localparam logic [1:0] RegAngularGain = 2'd1;
   localparam logic [1:0] RegDistTol = 2'd2;
   localparam logic [1:0] RegAngleTol = 2'd3;

   localparam logic [1:0] ModeRotate = 2'd0;
   localparam logic [1:0] ModeDrive = 2'd1;
   localparam logic [1:0] ModeStop = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP, ST_ITER, ST_SCALE, ST_DECIDE, ST_GAIN, ST_OUT
   } state_type;

   typedef struct packed {
      logic set_goal;
      logic prep;
      logic iter;
      logic scale;
      logic decide;
      logic gain;
      logic load_out;
   } cmd_type;

   function automatic logic [ZW-1:0] atan_q24(input logic [4:0] i);
      logic [ZW-1:0] r;
      unique case (i)
         5'd0: r = 28'd13176795;  5'd1: r = 28'd7778716;
         5'd2: r = 28'd4110060;   5'd3: r = 28'd2086331;
         5'd4: r = 28'd1047214;   5'd5: r = 28'd524117;
         5'd6: r = 28'd262123;    5'd7: r = 28'd131069;
         5'd8: r = 28'd65536;     5'd9: r = 28'd32768;
         5'd10: r = 28'd16384;    5'd11: r = 28'd8192;
         5'd12: r = 28'd4096;     5'd13: r = 28'd2048;
         5'd14: r = 28'd1024;     5'd15: r = 28'd512;
         5'd16: r = 28'd256;      5'd17: r = 28'd128;
         5'd18: r = 28'd64;       5'd19: r = 28'd32;
         5'd20: r = 28'd16;       5'd21: r = 28'd8;
         5'd22: r = 28'd4;        5'd23: r = 28'd2;
         default: r = '0;
      endcase
      return r;
   endfunction
endpackage

[src/gtg_req_if.sv]
// Valid/ready channel interfaces: request, response and register write
interface gtg_req_if;
   logic valid;
   logic ready;
   logic operation;
   logic signed [23:0] pos_x;
   logic signed [23:0] pos_y;
   logic signed [18:0] heading;
   modport source (output valid, operation, pos_x, pos_y, heading, input ready);
   modport sink (input valid, operation, pos_x, pos_y, heading, output ready);
endinterface

interface gtg_rsp_if;
   logic valid;
   logic ready;
   logic [23:0] forward_velocity;
   logic signed [17:0] turn_rate;
   logic [1:0] motion_mode;
   modport source (output valid, forward_velocity, turn_rate, motion_mode, input ready);
   modport sink (input valid, forward_velocity, turn_rate, motion_mode, output ready);
endinterface

interface gtg_csr_if;
   logic valid;
   logic ready;
   logic [1:0] index;
   logic [16:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[src/gtg_ctrl.sv]
// Sequencer of the go-to-goal controller
module gtg_ctrl
   import gtg_pkg::*;
#(
   parameter int CORDIC_ITERATIONS = CordicIterationsDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_operation,
   output logic    req_ready,
   input  logic    rsp_busy,
   output cmd_type cmd,
   output logic [4:0] iter_idx
);
   localparam int NIter = (CORDIC_ITERATIONS < AtanEntries) ? CORDIC_ITERATIONS : AtanEntries;

   state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;

   assign iter_idx = cnt_ff;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (!req_operation) cmd.set_goal = 1'b1;
               else begin
                  cmd.prep = 1'b1;
                  cnt_in = '0;
                  state_in = ST_ITER;
               end
            end
         end
         ST_ITER: begin
            cmd.iter = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(NIter - 1)) state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.gain = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_busy) begin
               cmd.load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

[src/gtg_dp.sv]
// Datapath: goal store, CORDIC, error wrap, gains, response register
`include "go_to_goal_heading_controller_assert.svh"
module gtg_dp
   import gtg_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  cmd_type cmd,
   input  logic [4:0] iter_idx,
   input  logic signed [23:0] in_x,
   input  logic signed [23:0] in_y,
   input  logic signed [18:0] in_heading,
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [16:0] csr_data,
   input  logic rsp_ready,
   output logic rsp_valid,
   output logic rsp_busy,
   output logic [23:0] rsp_fwd,
   output logic signed [17:0] rsp_turn,
   output logic [1:0] rsp_mode
);
   logic [16:0] lin_gain_ff, ang_gain_ff;
   logic [15:0] dist_tol_ff, ang_tol_ff;
   logic signed [23:0] goal_x_ff, goal_y_ff;
   logic moving_ff;
   logic signed [VW-1:0] x_ff, y_ff;
   logic signed [ZW-1:0] z_ff;
   logic signed [18:0] hd_ff;
   logic [40:0] dist_ff;         // distance Q16 (large headroom)
   logic signed [21:0] err_ff;
   logic [1:0] mode_ff;
   logic signed [43:0] prod_ff;  // 25 bit distance or 22 bit error times 17 bit gain, signed
   logic valid_ff;
   logic [23:0] fwd_ff;
   logic signed [17:0] turn_ff;
   logic [1:0] omode_ff;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         lin_gain_ff <= 17'd32768;
         ang_gain_ff <= 17'd32768;
         dist_tol_ff <= 16'd66;
         ang_tol_ff <= 16'd66;
      end else if (csr_we) begin
         unique case (csr_index)
            RegLinearGain: lin_gain_ff <= csr_data;
            RegAngularGain: ang_gain_ff <= csr_data;
            RegDistTol: dist_tol_ff <= csr_data[15:0];
            RegAngleTol: ang_tol_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // prep vector: difference with guard bits and quadrant fold
   logic signed [VW-1:0] dx, dy;
   assign dx = VW'(signed'(25'(goal_x_ff) - 25'(in_x))) <<< 8;
   assign dy = VW'(signed'(25'(goal_y_ff) - 25'(in_y))) <<< 8;

   // one CORDIC micro-rotation
   logic signed [VW-1:0] xs, ys;
   logic signed [ZW-1:0] at;
   assign xs = x_ff >>> iter_idx;
   assign ys = y_ff >>> iter_idx;
   assign at = signed'(atan_q24(iter_idx));

   // distance scaling
   logic [VW-2:0] xpos;
   logic [60:0] kprod;
   assign xpos = x_ff[VW-1] ? '0 : x_ff[VW-2:0];
   assign kprod = 61'(xpos) * 61'(CordicKQ24) + (61'd1 << 31);

   // error wrap
   logic signed [ZW-1:0] brg;
   logic signed [21:0] e0, ew;
   assign brg = (z_ff + ZW'(128)) >>> 8;
   assign e0 = 22'(brg) - 22'(hd_ff);
   always_comb begin
      if (e0 > 22'(PiQ16)) ew = e0 - 22'(TwoPiQ16);
      else if (e0 < -22'(PiQ16)) ew = e0 + 22'(TwoPiQ16);
      else ew = e0;
   end
   logic [21:0] aerr;
   assign aerr = err_ff[21] ? 22'(-err_ff) : 22'(err_ff);

   // main datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff <= GoalReset;
         goal_y_ff <= GoalReset;
         moving_ff <= 1'b0;
      end else begin
         if (cmd.set_goal) begin
            goal_x_ff <= in_x;
            goal_y_ff <= in_y;
            moving_ff <= 1'b1;
         end
         if (cmd.decide && !(moving_ff && dist_ff > 41'(dist_tol_ff)))
            moving_ff <= 1'b0;
      end
      if (cmd.prep) begin
         hd_ff <= in_heading;
         if (dx < 0) begin
            if (dy >= 0) begin
               x_ff <= dy; y_ff <= -dx; z_ff <= HalfPiQ24;
            end else begin
               x_ff <= -dy; y_ff <= dx; z_ff <= -HalfPiQ24;
            end
         end else begin
            x_ff <= dx; y_ff <= dy; z_ff <= '0;
         end
      end
      if (cmd.iter) begin
         if (y_ff >= 0) begin
            x_ff <= x_ff + ys; y_ff <= y_ff - xs; z_ff <= z_ff + at;
         end else begin
            x_ff <= x_ff - ys; y_ff <= y_ff + xs; z_ff <= z_ff - at;
         end
      end
      if (cmd.scale) begin
         dist_ff <= 41'(kprod >> 32);
         err_ff <= ew;
      end
      if (cmd.decide) begin
         if (moving_ff && dist_ff > 41'(dist_tol_ff)) begin
            if (aerr > 22'(ang_tol_ff)) begin
               mode_ff <= ModeRotate;
               prod_ff <= 44'(err_ff) * signed'(44'(ang_gain_ff)) + 44'sd32768;
            end else begin
               mode_ff <= ModeDrive;
               prod_ff <= signed'(44'(dist_ff[24:0])) * signed'(44'(lin_gain_ff))
                          + 44'sd32768;
            end
         end else begin
            mode_ff <= ModeStop;
            prod_ff <= '0;
         end
      end
   end

   // saturate products
   logic signed [24:0] q;
   logic [23:0] fwd_sat;
   logic signed [17:0] turn_sat;
   assign q = 25'(prod_ff >>> 16);
   always_comb begin
      fwd_sat = '0;
      turn_sat = '0;
      if (mode_ff == ModeDrive) begin
         if ((prod_ff >>> 16) > 44'sd16777215) fwd_sat = '1;
         else fwd_sat = q[23:0];
      end else if (mode_ff == ModeRotate) begin
         if (q > 25'sd131071) turn_sat = 18'sd131071;
         else if (q < -25'sd131072) turn_sat = -18'sd131072;
         else turn_sat = q[17:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.gain) begin
         fwd_ff <= fwd_sat;
         turn_ff <= turn_sat;
         omode_ff <= mode_ff;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (cmd.load_out) valid_ff <= 1'b1;
      else if (rsp_ready) valid_ff <= 1'b0;
   end
   logic [23:0] ofwd_ff;
   logic signed [17:0] oturn_ff;
   logic [1:0] omd_ff;
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         ofwd_ff <= fwd_ff;
         oturn_ff <= turn_ff;
         omd_ff <= omode_ff;
      end
   end
   assign rsp_valid = valid_ff;
   assign rsp_busy = valid_ff && !rsp_ready;
   assign rsp_fwd = ofwd_ff;
   assign rsp_turn = oturn_ff;
   assign rsp_mode = omd_ff;

   `GTG_ASSERT_IMPL(a_no_overwrite, clock, reset, rsp_busy |-> !cmd.load_out,
      "response overwritten while stalled")
   `GTG_ASSERT_IMPL(a_mode_legal, clock, reset, rsp_valid |-> rsp_mode != 2'd3,
      "illegal motion mode")
   `GTG_ASSERT_IMPL(a_stop_zero, clock, reset,
      rsp_valid && rsp_mode == ModeStop |-> rsp_fwd == '0 && rsp_turn == '0,
      "stopped response with nonzero command")
endmodule

[src/go_to_goal_heading_controller.sv]
// Top level of the go-to-goal heading controller
//  channel  | dir | transaction
//  req_     | in  | operation, pos_x, pos_y, heading
//  rsp_     | out | forward_velocity, turn_rate, motion_mode
//  csr_     | in  | index, data (register write)
// A set-goal transaction is taken in IDLE without leaving it; a control transaction
// steps through ITER, SCALE, DECIDE, GAIN and OUT, with ITER paced by the shared CORDIC stage
// running one micro-rotation per cycle. Reset is synchronous and restores
// registers and goal. A stalled response holds the sequencer before reload.
module go_to_goal_heading_controller
   import gtg_pkg::*;
#(
   parameter int CORDIC_ITERATIONS = CordicIterationsDefault
) (
   input logic clock,
   input logic reset,
   gtg_req_if.sink req,
   gtg_rsp_if.source rsp,
   gtg_csr_if.sink csr
);
   cmd_type cmd;
   logic [4:0] iter_idx;
   logic rsp_busy;

   assign csr.ready = 1'b1;

   gtg_ctrl #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_operation(req.operation), .req_ready(req.ready),
      .rsp_busy, .cmd, .iter_idx
   );

   gtg_dp u_dp (
      .clock, .reset, .cmd, .iter_idx,
      .in_x(req.pos_x), .in_y(req.pos_y), .in_heading(req.heading),
      .csr_we(csr.valid), .csr_index(csr.index), .csr_data(csr.data),
      .rsp_ready(rsp.ready), .rsp_valid(rsp.valid), .rsp_busy,
      .rsp_fwd(rsp.forward_velocity), .rsp_turn(rsp.turn_rate),
      .rsp_mode(rsp.motion_mode)
   );
endmodule
